// ----- sv/tedet_pkg.sv -----
// shared types and codes for the text encoding detector
`default_nettype none

package tedet_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned ENC_W  = 3;
    localparam int unsigned POS_W  = 3;
    localparam int unsigned LEAD_W = 32;

    // encoding codes
    localparam logic [ENC_W-1:0] ENC_ASCII   = 3'd0;
    localparam logic [ENC_W-1:0] ENC_ANSI    = 3'd1;
    localparam logic [ENC_W-1:0] ENC_UTF8    = 3'd2;
    localparam logic [ENC_W-1:0] ENC_UTF16LE = 3'd3;
    localparam logic [ENC_W-1:0] ENC_UTF32LE = 3'd4;
    localparam logic [ENC_W-1:0] ENC_UTF7    = 3'd5;

    // byte order mark bytes
    localparam logic [BYTE_W-1:0] BOM8_B0  = 8'hEF;
    localparam logic [BYTE_W-1:0] BOM8_B1  = 8'hBB;
    localparam logic [BYTE_W-1:0] BOM8_B2  = 8'hBF;
    localparam logic [BYTE_W-1:0] BOM16_B0 = 8'hFF;
    localparam logic [BYTE_W-1:0] BOM16_B1 = 8'hFE;
    localparam logic [BYTE_W-1:0] BOM7_B0  = 8'h2B;
    localparam logic [BYTE_W-1:0] BOM7_B1  = 8'h2F;
    localparam logic [BYTE_W-1:0] BOM7_B2  = 8'h76;

    // facts about the buffer including the byte just taken
    typedef struct packed {
        logic [POS_W-1:0]  pos;        // position of the byte just taken, 4..7 wrap
        logic [LEAD_W-1:0] lead;       // first four bytes, byte i at bits 8i+7:8i
        logic [1:0]        zero_words; // aligned zero 16-bit words, saturating
        logic              wide;       // some aligned 32-bit word above 0x1FFFFF
        logic [1:0]        nuls;       // NUL bytes outside tails, saturating
        logic              non_ascii;  // some byte with bit 7 set
        logic              utf8_ok;    // valid UTF-8 with no truncated tail
    } tedet_facts_t;

endpackage

`default_nettype wire

// ----- sv/tedet_scan.sv -----
// per-byte state tracking: position, leading bytes, word checks, UTF-8 validity
`default_nettype none

module tedet_scan (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          accept,
    input  wire logic [tedet_pkg::BYTE_W-1:0]  data_byte,
    input  wire logic                          last_byte,
    output tedet_pkg::tedet_facts_t            facts
);
    import tedet_pkg::*;

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [LEAD_W-1:0] lead_reg, lead_next;
    logic [23:0]       word_reg, word_next;
    logic [1:0]        tails_reg, tails_next;
    logic              valid_reg, valid_next;
    logic [1:0]        nul_reg, nul_next;
    logic              na_reg, na_next;
    logic [1:0]        zw_reg, zw_next;
    logic              wide_reg, wide_next;

    logic [1:0]        phase;
    logic [BYTE_W-1:0] prev_byte;

    assign phase     = pos_reg[1:0];
    assign prev_byte = phase[1] ? word_reg[23:16] : word_reg[7:0];

    // leading bytes, aligned word checks and position
    always_comb begin
        lead_next = lead_reg;
        if (pos_reg < 3'd4) begin
            lead_next[pos_reg[1:0]*BYTE_W +: BYTE_W] = data_byte;
        end
        zw_next   = zw_reg;
        wide_next = wide_reg;
        word_next = word_reg;
        if (phase[0] && prev_byte == '0 && data_byte == '0 && zw_reg < 2'd2) begin
            zw_next = zw_reg + 2'd1;
        end
        if (phase == 2'd3) begin
            if (data_byte != '0 || word_reg[23:21] != 3'b000) begin
                wide_next = 1'b1;
            end
            word_next = '0;
        end else begin
            word_next[phase*BYTE_W +: BYTE_W] = data_byte;
        end
        pos_next = (pos_reg == 3'd7) ? 3'd4 : pos_reg + 3'd1;
    end

    // utf-8 sequence tracking and nul count
    always_comb begin
        tails_next = tails_reg;
        valid_next = valid_reg;
        nul_next   = nul_reg;
        na_next    = na_reg;
        if (tails_reg != 2'd0) begin
            if (data_byte[7]) begin
                na_next = 1'b1;
            end
            if (data_byte[7:6] != 2'b10) begin
                valid_next = 1'b0;
                tails_next = 2'd0;
            end else begin
                tails_next = tails_reg - 2'd1;
            end
        end else if (data_byte == '0) begin
            if (nul_reg < 2'd2) begin
                nul_next = nul_reg + 2'd1;
            end
        end else if (data_byte[7]) begin
            na_next = 1'b1;
            if (valid_reg) begin
                if (!data_byte[6]) begin
                    valid_next = 1'b0;
                end else if (!data_byte[5]) begin
                    tails_next = 2'd1;
                    if (data_byte[7:1] == 7'h60) begin
                        valid_next = 1'b0;
                    end
                end else if (!data_byte[4]) begin
                    tails_next = 2'd2;
                end else if (!data_byte[3]) begin
                    tails_next = 2'd3;
                    if (data_byte >= 8'hF5) begin
                        valid_next = 1'b0;
                    end
                end else begin
                    valid_next = 1'b0;
                end
            end
        end
    end

    // facts after this byte
    always_comb begin
        facts.pos        = pos_reg;
        facts.lead       = lead_next;
        facts.zero_words = zw_next;
        facts.wide       = wide_next;
        facts.nuls       = nul_next;
        facts.non_ascii  = na_next;
        facts.utf8_ok    = valid_next && (tails_next == 2'd0);
    end

    // state registers, cleared after the final byte
    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && last_byte)) begin
            pos_reg   <= '0;
            lead_reg  <= '0;
            word_reg  <= '0;
            tails_reg <= '0;
            valid_reg <= 1'b1;
            nul_reg   <= '0;
            na_reg    <= 1'b0;
            zw_reg    <= '0;
            wide_reg  <= 1'b0;
        end else if (accept) begin
            pos_reg   <= pos_next;
            lead_reg  <= lead_next;
            word_reg  <= word_next;
            tails_reg <= tails_next;
            valid_reg <= valid_next;
            nul_reg   <= nul_next;
            na_reg    <= na_next;
            zw_reg    <= zw_next;
            wide_reg  <= wide_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/tedet_classify.sv -----
// encoding decision from byte order mark and gathered buffer facts
`default_nettype none

module tedet_classify (
    input  wire tedet_pkg::tedet_facts_t      facts,
    output logic [tedet_pkg::ENC_W-1:0]       encoding
);
    import tedet_pkg::*;

    logic [BYTE_W-1:0] b0, b1, b2, b3;
    logic              len_ge2, len_ge3, len_ge4, len_ge5;

    assign b0 = facts.lead[7:0];
    assign b1 = facts.lead[15:8];
    assign b2 = facts.lead[23:16];
    assign b3 = facts.lead[31:24];

    // length of the buffer is position plus one
    assign len_ge2 = facts.pos >= 3'd1;
    assign len_ge3 = facts.pos >= 3'd2;
    assign len_ge4 = facts.pos >= 3'd3;
    assign len_ge5 = facts.pos[2];

    // priority: marks first, then statistics
    always_comb begin
        if (len_ge3 && b0 == BOM8_B0 && b1 == BOM8_B1 && b2 == BOM8_B2) begin
            encoding = ENC_UTF8;
        end else if (len_ge4 && b0 == BOM16_B0 && b1 == BOM16_B1 &&
                     b2 == '0 && b3 == '0) begin
            encoding = ENC_UTF32LE;
        end else if (len_ge2 && b0 == BOM16_B0 && b1 == BOM16_B1) begin
            encoding = ENC_UTF16LE;
        end else if (len_ge5 && b0 == BOM7_B0 && b1 == BOM7_B1 && b2 == BOM7_B2) begin
            encoding = ENC_UTF7;
        end else if (facts.zero_words[1] && !facts.wide) begin
            encoding = ENC_UTF32LE;
        end else if (facts.nuls[1]) begin
            encoding = ENC_UTF16LE;
        end else if (facts.non_ascii && facts.utf8_ok) begin
            encoding = ENC_UTF8;
        end else if (facts.non_ascii) begin
            encoding = ENC_ANSI;
        end else begin
            encoding = ENC_ASCII;
        end
    end

endmodule

`default_nettype wire

// ----- sv/text_encoding_detector_unit.sv -----
// top level of the text encoding detector: byte stream in, one encoding code per buffer out
//
//  channel  | ports                        | contents
//  ---------+------------------------------+---------------------------------------
//  input    | s_tvalid s_tready s_tdata    | tdata[7:0] data_byte, tlast last_byte
//           | s_tlast                      |
//  result   | m_tvalid m_tready m_tdata    | tdata[2:0] encoding, tdata[7:3] zero
//
// One byte is taken per cycle while s_tready is high; its state update and
// the decision run in the same cycle between the state registers and the
// output register. The code for a buffer appears in the output register in
// the cycle after its final byte is taken. A waiting result stalls all input:
// s_tready is low in every cycle in which a result is held and m_tready is low.
// aresetn is synchronous, active low, and clears all buffer state.
`default_nettype none

module text_encoding_detector_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // last_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata    // [2:0] encoding, [7:3] zero
);
    import tedet_pkg::*;

    tedet_facts_t       facts;
    logic [ENC_W-1:0]   code;
    logic               s_xfer;
    logic               out_valid_reg, out_valid_next;
    logic [ENC_W-1:0]   out_code_reg;

    assign s_tready = !out_valid_reg || m_tready;
    assign s_xfer   = s_tvalid && s_tready;

    tedet_scan u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (s_xfer),
        .data_byte (s_tdata),
        .last_byte (s_tlast),
        .facts     (facts)
    );

    tedet_classify u_classify (
        .facts    (facts),
        .encoding (code)
    );

    // output register handshake
    always_comb begin
        out_valid_next = out_valid_reg;
        if (s_xfer && s_tlast) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (s_xfer && s_tlast) begin
            out_code_reg <= code;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(8 - ENC_W){1'b0}}, out_code_reg};

`ifndef NO_ASSERTIONS
    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && s_tlast) |=> m_tvalid)
        else $error("final byte transfer produced no result");

    a_no_spurious_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (!(s_xfer && s_tlast) && (!m_tvalid || m_tready)) |=> !m_tvalid)
        else $error("result appeared without a final byte");

    a_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2:0] <= ENC_UTF7))
        else $error("encoding code out of range");

    a_code_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// self-checking testbench for the text encoding detector: directed buffers, then random ones
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tedet_pkg::*;

    localparam int RANDOM_BYTES = 1700;
    localparam int CALM_AFTER   = 1500;
    localparam int MAX_SHOWN    = 10;

    // one directed transfer; the code is only read on the final byte of a buffer
    typedef struct packed {
        logic [7:0]       b;
        logic             last;
        logic [ENC_W-1:0] code;
    } plan_row_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;

    // expected encoding codes, oldest first
    logic [ENC_W-1:0] expected_codes[$];
    logic [7:0]       text_q[$];
    int               mismatches = 0;
    int               stall_left = 0;
    logic             calm_tail = 1'b0;

    // detector state mirrored by the predictor
    logic [2:0]  pos_q;
    logic [39:0] head_q;
    logic [23:0] word_q;
    logic [1:0]  tails_q;
    logic        valid_q;
    logic [1:0]  nuls_q;
    logic        nonascii_q;
    logic [1:0]  zwords_q;
    logic        wide_q;

    plan_row_t plan [28] = '{
        // lone NUL, lone 0xFF
        '{8'h00, 1'b1, ENC_ASCII},
        '{8'hFF, 1'b1, ENC_ANSI},
        // UTF-8 mark
        '{8'hEF, 1'b0, ENC_ASCII}, '{8'hBB, 1'b0, ENC_ASCII}, '{8'hBF, 1'b1, ENC_UTF8},
        // UTF-32LE mark
        '{8'hFF, 1'b0, ENC_ASCII}, '{8'hFE, 1'b0, ENC_ASCII}, '{8'h00, 1'b0, ENC_ASCII},
        '{8'h00, 1'b1, ENC_UTF32LE},
        // UTF-16LE mark
        '{8'hFF, 1'b0, ENC_ASCII}, '{8'hFE, 1'b1, ENC_UTF16LE},
        // UTF-7 mark with the minimum length
        '{8'h2B, 1'b0, ENC_ASCII}, '{8'h2F, 1'b0, ENC_ASCII}, '{8'h76, 1'b0, ENC_ASCII},
        '{8'h7F, 1'b0, ENC_ASCII}, '{8'h2D, 1'b1, ENC_UTF7},
        // overlong lead still eats its tail
        '{8'hC0, 1'b0, ENC_ASCII}, '{8'h80, 1'b1, ENC_ANSI},
        // truncated three-byte sequence
        '{8'hE2, 1'b0, ENC_ASCII}, '{8'h82, 1'b1, ENC_ANSI},
        // out-of-range four-byte lead
        '{8'hF5, 1'b0, ENC_ASCII}, '{8'h80, 1'b0, ENC_ASCII}, '{8'h80, 1'b0, ENC_ASCII},
        '{8'h80, 1'b1, ENC_ANSI},
        // stray tail, lead with no tails
        '{8'h80, 1'b1, ENC_ANSI},
        '{8'hF8, 1'b1, ENC_ANSI},
        // valid two-byte sequence
        '{8'hC3, 1'b0, ENC_ASCII}, '{8'hA9, 1'b1, ENC_UTF8}
    };

    text_encoding_detector_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    task automatic clear_detector_state();
        pos_q      = 3'd0;
        head_q     = 40'd0;
        word_q     = 24'd0;
        tails_q    = 2'd0;
        valid_q    = 1'b1;
        nuls_q     = 2'd0;
        nonascii_q = 1'b0;
        zwords_q   = 2'd0;
        wide_q     = 1'b0;
    endtask

    // advance the mirrored state by one byte; on the final byte give the code
    task automatic detect_encoding(input logic [7:0] b, input logic last,
                                   output logic done, output logic [ENC_W-1:0] enc);
        int         pos;
        int         ph;
        int         len;
        logic [7:0] prev;
        logic [7:0] h0, h1, h2, h3;
        pos  = pos_q;
        ph   = pos % 4;
        done = 1'b0;
        enc  = ENC_ASCII;
        if (pos < 5)
            head_q[8*pos +: 8] = b;

        // aligned 16-bit and 32-bit words
        if (ph == 1 || ph == 3) begin
            prev = word_q[8*(ph-1) +: 8];
            if (prev == 8'h00 && b == 8'h00 && zwords_q < 2'd2)
                zwords_q = zwords_q + 2'd1;
        end
        if (ph == 3) begin
            if (b != 8'h00 || word_q[23:21] != 3'b000)
                wide_q = 1'b1;
            word_q = 24'd0;
        end else begin
            word_q[8*ph +: 8] = b;
        end

        // utf-8 validity and nul counting
        if (tails_q != 2'd0) begin
            if (b[7])
                nonascii_q = 1'b1;
            if (b[7:6] != 2'b10) begin
                valid_q = 1'b0;
                tails_q = 2'd0;
            end else begin
                tails_q = tails_q - 2'd1;
            end
        end else if (b == 8'h00) begin
            if (nuls_q < 2'd2)
                nuls_q = nuls_q + 2'd1;
        end else if (b[7]) begin
            nonascii_q = 1'b1;
            if (valid_q) begin
                if (!b[6]) begin
                    valid_q = 1'b0;
                end else if (!b[5]) begin
                    tails_q = 2'd1;
                    if (b == 8'hC0 || b == 8'hC1)
                        valid_q = 1'b0;
                end else if (!b[4]) begin
                    tails_q = 2'd2;
                end else if (!b[3]) begin
                    tails_q = 2'd3;
                    if (b >= 8'hF5)
                        valid_q = 1'b0;
                end else begin
                    valid_q = 1'b0;
                end
            end
        end

        pos_q = (pos == 7) ? 3'd4 : 3'(pos + 1);
        if (last) begin
            len = pos + 1;
            if (tails_q != 2'd0)
                valid_q = 1'b0;
            h0 = head_q[7:0];
            h1 = head_q[15:8];
            h2 = head_q[23:16];
            h3 = head_q[31:24];
            if (len >= 3 && h0 == BOM8_B0 && h1 == BOM8_B1 && h2 == BOM8_B2)
                enc = ENC_UTF8;
            else if (len >= 4 && h0 == BOM16_B0 && h1 == BOM16_B1 && h2 == 8'h00 && h3 == 8'h00)
                enc = ENC_UTF32LE;
            else if (len >= 2 && h0 == BOM16_B0 && h1 == BOM16_B1)
                enc = ENC_UTF16LE;
            else if (len >= 5 && h0 == BOM7_B0 && h1 == BOM7_B1 && h2 == BOM7_B2)
                enc = ENC_UTF7;
            else if (zwords_q >= 2'd2 && !wide_q)
                enc = ENC_UTF32LE;
            else if (nuls_q >= 2'd2)
                enc = ENC_UTF16LE;
            else if (nonascii_q && valid_q)
                enc = ENC_UTF8;
            else if (nonascii_q)
                enc = ENC_ANSI;
            else
                enc = ENC_ASCII;
            done = 1'b1;
            clear_detector_state();
        end
    endtask

    // one input transfer, with an optional idle burst in front of it
    task automatic send_byte(input logic [7:0] b, input logic last,
                             input logic typed, input logic [ENC_W-1:0] code);
        int               gap;
        logic             done;
        logic [ENC_W-1:0] enc;
        if (!calm_tail && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 18);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        detect_encoding(b, last, done, enc);
        if (done)
            expected_codes.push_back(typed ? code : enc);
    endtask

    // append one UTF-8 character with a random code point of random length
    task automatic add_utf8_char();
        int n;
        n = $urandom_range(1, 4);
        case (n)
            1: text_q.push_back(8'($urandom_range(8'h01, 8'h7F)));
            2: text_q.push_back(8'($urandom_range(8'hC2, 8'hDF)));
            3: text_q.push_back(8'($urandom_range(8'hE0, 8'hEF)));
            default: text_q.push_back(8'($urandom_range(8'hF0, 8'hF4)));
        endcase
        repeat (n - 1) text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
    endtask

    // fill text_q with one random buffer of some flavor
    task automatic build_buffer();
        int         kind;
        int         n;
        int         k;
        logic [7:0] odd_bytes [16];
        odd_bytes = '{8'hC0, 8'hC1, 8'hC2, 8'hDF, 8'hE0, 8'hEF, 8'hF0, 8'hF4,
                      8'hF5, 8'hF7, 8'hF8, 8'hFF, 8'h80, 8'hBF, 8'h00, 8'h41};
        text_q.delete();
        kind = $urandom_range(0, 9);
        case (kind)
            0: begin
                n = $urandom_range(1, 12);
                repeat (n) text_q.push_back(8'($urandom));
            end
            1: begin
                n = $urandom_range(1, 16);
                repeat (n)
                    text_q.push_back(($urandom_range(0, 15) == 0) ? 8'h00
                                     : 8'($urandom_range(8'h20, 8'h7E)));
            end
            2: begin
                n = $urandom_range(1, 6);
                repeat (n) add_utf8_char();
                // some sequences get a corrupted byte or lose their end
                if ($urandom_range(0, 3) == 0)
                    text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom);
                if (text_q.size() > 1 && $urandom_range(0, 5) == 0)
                    void'(text_q.pop_back());
            end
            3: begin
                n = $urandom_range(1, 8);
                repeat (n) begin
                    text_q.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom)
                                     : 8'($urandom_range(8'h20, 8'h7E)));
                    text_q.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'h00);
                end
                if ($urandom_range(0, 3) == 0)
                    void'(text_q.pop_back());
            end
            4: begin
                n = $urandom_range(1, 5);
                repeat (n) begin
                    text_q.push_back(8'($urandom));
                    text_q.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00);
                    text_q.push_back(($urandom_range(0, 5) == 0)
                                     ? 8'($urandom_range(8'h00, 8'h3F)) : 8'h00);
                    text_q.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h00);
                end
                if ($urandom_range(0, 3) == 0)
                    void'(text_q.pop_back());
            end
            5: begin
                // a mark, sometimes cut short, followed by varied content
                case ($urandom_range(0, 3))
                    0: begin
                        text_q.push_back(BOM8_B0);
                        text_q.push_back(BOM8_B1);
                        text_q.push_back(BOM8_B2);
                    end
                    1: begin
                        text_q.push_back(BOM16_B0);
                        text_q.push_back(BOM16_B1);
                        text_q.push_back(8'h00);
                        text_q.push_back(8'h00);
                    end
                    2: begin
                        text_q.push_back(BOM16_B0);
                        text_q.push_back(BOM16_B1);
                    end
                    default: begin
                        text_q.push_back(BOM7_B0);
                        text_q.push_back(BOM7_B1);
                        text_q.push_back(BOM7_B2);
                    end
                endcase
                k = $urandom_range(1, text_q.size());
                while (text_q.size() > k && $urandom_range(0, 1) == 0)
                    void'(text_q.pop_back());
                n = $urandom_range(0, 6);
                repeat (n)
                    text_q.push_back(($urandom_range(0, 1) == 0) ? 8'($urandom)
                                     : 8'($urandom_range(8'h20, 8'h7E)));
            end
            6: begin
                n = $urandom_range(13, 40);
                repeat (n) text_q.push_back(8'($urandom));
            end
            7: begin
                n = $urandom_range(1, 12);
                repeat (n)
                    text_q.push_back(($urandom_range(0, 2) != 0) ? 8'h00 : 8'($urandom));
            end
            8: begin
                n = $urandom_range(1, 10);
                repeat (n) text_q.push_back(odd_bytes[$urandom_range(0, 15)]);
            end
            default: text_q.push_back(8'($urandom));
        endcase
    endtask

    // stimulus: reset, directed rows, then random buffers
    initial begin
        int sent;
        clear_detector_state();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i])
            send_byte(plan[i].b, plan[i].last, plan[i].last, plan[i].code);

        sent = 0;
        while (sent < RANDOM_BYTES) begin
            build_buffer();
            foreach (text_q[i]) begin
                if (sent > CALM_AFTER)
                    calm_tail = 1'b1;
                send_byte(text_q[i], (i == text_q.size() - 1), 1'b0, ENC_ASCII);
                sent++;
            end
        end
        s_tvalid <= 1'b0;

        while (expected_codes.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        if (mismatches == 0)
            $display("** text_encoding_detector_unit: PASSED **");
        else
            $display("** text_encoding_detector_unit: FAILED **");
        $finish;
    end

    // result side ready with random stall bursts
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (aresetn && !calm_tail && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(1, 18) - 1;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // compare each result transfer with the oldest expected code
    always @(posedge aclk) begin
        logic [ENC_W-1:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_codes.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("%0t: unexpected result transfer, tdata=%h", $realtime, m_tdata);
            end else begin
                want = expected_codes.pop_front();
                if (m_tdata !== {5'b00000, want}) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("%0t: encoding mismatch, expected %0d, got tdata=%h",
                                 $realtime, want, m_tdata);
                end
            end
        end
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("** text_encoding_detector_unit: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
